// ===== sv/fbk_pkg.sv =====
// fbk_pkg: shared types, constants and helper functions for the fnv1a base-36 key block
// used by every module of the block; depends on nothing
`default_nettype none

package fbk_pkg;

  // hash constants
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // base-36 readout
  localparam int unsigned KEY_DIGITS = 7;
  localparam int unsigned DIG_IDX_W  = $clog2(KEY_DIGITS);
  localparam logic [29:0] DIV9_MUL   = 30'h38E38E39;  // ceil(2^33 / 9)
  localparam int unsigned DIV9_SHIFT = 33;
  localparam logic [6:0]  ASCII_ZERO = 7'd48;
  localparam logic [6:0]  ASCII_A_OFS = 7'd87;       // 'a' minus ten
  localparam logic [5:0]  DEC_DIGITS = 6'd10;

  // front-to-back queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  digit_char;
    logic [31:0] key_hash;
    logic        last_digit;
  } out_item_t;

  // finished hash moving between front, queue and back
  typedef struct packed {
    logic        valid;
    logic [31:0] hash;
  } hash_xfer_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

  // one fnv-1a round, product kept modulo 2^32
  function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

  // v / 36 as (v >> 2) / 9 through a reciprocal multiply
  function automatic logic [31:0] div36(input logic [31:0] v);
    logic [59:0] p;
    p = {30'd0, v[31:2]} * {30'd0, DIV9_MUL};
    return {5'd0, p[59:DIV9_SHIFT]};
  endfunction

  // remainder 0..35 to ascii 0-9, a-z
  function automatic logic [6:0] digit_ascii(input logic [5:0] r);
    logic [6:0] c;
    if (r < DEC_DIGITS) begin
      c = ASCII_ZERO + {1'b0, r};
    end else begin
      c = ASCII_A_OFS + {1'b0, r};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/fbk_front.sv =====
// fbk_front: running fnv-1a hash, one byte per transfer
// depends on fbk_pkg; hands each finished hash to the queue
`default_nettype none

module fbk_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic               full,
  input  wire fbk_pkg::in_item_t  in_item,
  output fbk_pkg::hash_xfer_t     q_wr
);

  logic [31:0] hash_r, hash_nxt;
  logic [31:0] mixed;
  logic        accept;

  assign accept = push & ~full;

  // hash the byte if it belongs to the string
  always_comb begin
    mixed = in_item.byte_valid ? fbk_pkg::fnv_round(hash_r, in_item.data_byte) : hash_r;
    hash_nxt   = hash_r;
    q_wr.valid = 1'b0;
    q_wr.hash  = mixed;
    if (accept) begin
      if (in_item.end_of_string) begin
        hash_nxt   = fbk_pkg::FNV_BASIS;
        q_wr.valid = 1'b1;
      end else begin
        hash_nxt = mixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= fbk_pkg::FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fbk_queue.sv =====
// fbk_queue: short queue of finished hashes between front and back
// depends on fbk_pkg for the transfer struct
`default_nettype none

module fbk_queue #(
  parameter int unsigned DEPTH = fbk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fbk_pkg::hash_xfer_t q_wr,
  output logic                     full,
  output fbk_pkg::hash_xfer_t      q_head,
  input  wire logic                q_pop
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [31:0]      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full         = (cnt_r == CNT_W'(DEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.hash  = slot_r[rd_ptr_r];
  assign do_wr        = q_wr.valid & ~full;
  assign do_rd        = q_pop & q_head.valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= q_wr.hash;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fbk_back.sv =====
// fbk_back: base-36 conversion of a finished hash and digit readout, most significant first
// depends on fbk_pkg; pulls hashes from fbk_queue
`default_nettype none

module fbk_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fbk_pkg::hash_xfer_t q_head,
  output logic                     q_pop,
  output logic                     empty,
  input  wire logic                pop,
  output fbk_pkg::out_item_t       out_item
);

  localparam int unsigned IW = fbk_pkg::DIG_IDX_W;

  fbk_pkg::back_state_t state_r, state_nxt;
  logic [31:0]   val_r, val_nxt;     // value still to convert
  logic [31:0]   quo_r, quo_nxt;     // val_r / 36, registered together with val_r
  logic [31:0]   hash_r, hash_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;     // digits written so far
  logic [IW-1:0] idx_r, idx_nxt;     // digit on the output
  logic [6:0]    dig_r [fbk_pkg::KEY_DIGITS];
  logic          dig_we;
  logic [31:0]   rem_full;
  logic [5:0]    rem;

  // remainder as val - 36 * quo
  assign rem_full = val_r - ((quo_r << 5) + (quo_r << 2));
  assign rem      = rem_full[5:0];

  // sequencer: load, convert low digit first, emit high digit first
  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    quo_nxt   = quo_r;
    hash_nxt  = hash_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    dig_we    = 1'b0;
    case (state_r)
      fbk_pkg::BK_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          val_nxt   = q_head.hash;
          quo_nxt   = fbk_pkg::div36(q_head.hash);
          hash_nxt  = q_head.hash;
          cnt_nxt   = '0;
          state_nxt = fbk_pkg::BK_CONV;
        end
      end
      fbk_pkg::BK_CONV: begin
        dig_we = 1'b1;
        if (quo_r == '0) begin
          idx_nxt   = cnt_r;
          state_nxt = fbk_pkg::BK_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          val_nxt = quo_r;
          quo_nxt = fbk_pkg::div36(quo_r);
        end
      end
      fbk_pkg::BK_EMIT: begin
        if (pop) begin
          if (idx_r == '0) begin
            state_nxt = fbk_pkg::BK_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = fbk_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbk_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    quo_r  <= quo_nxt;
    hash_r <= hash_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    if (dig_we) begin
      dig_r[cnt_r] <= fbk_pkg::digit_ascii(rem);
    end
  end

  // result channel
  assign empty               = (state_r != fbk_pkg::BK_EMIT);
  assign out_item.digit_char = dig_r[idx_r];
  assign out_item.key_hash   = hash_r;
  assign out_item.last_digit = (idx_r == '0);

endmodule

`default_nettype wire

// ===== sv/fnv1a_base36_key.sv =====
// fnv1a_base36_key: streaming fnv-1a hash with a base-36 key readout.
// Throughput: one byte per cycle on the input; input stalls only while the hash queue is full.
// Flow: a finished hash is written to the hash queue and loaded by the back end only when idle;
// it converts one digit per divide step (1..7 digits, low first), then emits high first with pop waits.
// Reset: synchronous, active low; hash returns to the offset basis, queue empties, no results.
`default_nettype none

module fnv1a_base36_key #(
  parameter int unsigned QUEUE_DEPTH = fbk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire fbk_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output fbk_pkg::out_item_t      out_item
);

  fbk_pkg::hash_xfer_t q_wr;
  fbk_pkg::hash_xfer_t q_head;
  logic                q_pop;

  // hashing front end
  fbk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_wr    (q_wr)
  );

  // finished hashes waiting for conversion
  fbk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .full   (full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  // digit conversion and readout
  fbk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

`ifndef SYNTH
  // a run keeps going and keeps its hash until the last digit
  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.last_digit) |=> (!empty && $stable(out_item.key_hash)))
    else $error("key run broke before last digit");

  // a hash below 36 is a single digit
  a_small_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.key_hash < 32'd36)) |-> out_item.last_digit)
    else $error("small hash gave more than one digit");

  // every shown digit is 0-9 or a-z
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_item.digit_char >= 7'd48 && out_item.digit_char <= 7'd57) ||
                (out_item.digit_char >= 7'd97 && out_item.digit_char <= 7'd122)))
    else $error("digit outside base-36 alphabet");

  // the back end only pulls a hash that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_head.valid && empty))
    else $error("queue read while empty or while emitting");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// testbench for fnv1a_base36_key: streams topic strings, predicts each base-36 key digit
// with its own fnv-1a model and checks every result transfer; depends on fbk_pkg and the dut
`timescale 1ns / 100ps

module testbench;

  localparam logic [31:0]   OFFSET_BASIS = 32'd2166136261;
  localparam logic [31:0]   HASH_PRIME   = 32'd16777619;
  localparam int            KEY_RADIX    = 36;
  localparam int            MAX_KEY_LEN  = 7;
  localparam int            RANDOM_ITEMS = 370;
  localparam logic [8*36-1:0] DIGIT_SET  = "0123456789abcdefghijklmnopqrstuvwxyz";

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  fbk_pkg::in_item_t  in_item = '0;
  logic               full;
  logic               empty;
  fbk_pkg::out_item_t out_item;

  fbk_pkg::in_item_t  topic_q[$];       // items still to be pushed
  fbk_pkg::out_item_t key_digit_q[$];   // digits the dut still owes
  logic      in_taken = 1'b0;
  int        cyc = 0;
  int        accepted = 0;
  int        errors = 0;
  int        total_items = 0;

  fnv1a_base36_key dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // one fnv-1a round, wraps at 32 bits
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * HASH_PRIME;
  endfunction

  function automatic void add_item(input logic [7:0] b, input logic valid, input logic eos);
    fbk_pkg::in_item_t it;
    it.data_byte     = b;
    it.byte_valid    = valid;
    it.end_of_string = eos;
    topic_q.insert(topic_q.size(), it);
    total_items++;
  endfunction

  // random stall, none inside the quiet window
  function automatic bit take_break();
    return !(cyc >= 400 && cyc < 1000) && ($urandom_range(99) < 31);
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      if (!push || in_taken) begin
        if (topic_q.size() != 0 && !take_break()) begin
          in_item <= topic_q.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= !take_break();
    end
  end

  // monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin : monitor
    logic [31:0]        topic_hash;
    logic [31:0]        rest;
    logic [6:0]         rev [MAX_KEY_LEN];
    fbk_pkg::out_item_t e;
    int                 n;
    int                 k;
    if (!rst_n) begin
      in_taken   <= 1'b0;
      topic_hash = OFFSET_BASIS;
    end else begin
      cyc      <= cyc + 1;
      in_taken <= push && !full;
      if (push && !full) begin
        accepted++;
        if (in_item.byte_valid) begin
          topic_hash = fnv_step(topic_hash, in_item.data_byte);
        end
        // end of string: digits least significant first, then queued in reading order
        if (in_item.end_of_string) begin
          rest = topic_hash;
          for (n = 0; n == 0 || (rest != 0 && n < MAX_KEY_LEN); n++) begin
            rev[n] = DIGIT_SET[8 * (35 - rest % KEY_RADIX) +: 7];
            rest   = rest / KEY_RADIX;
          end
          for (k = n - 1; k >= 0; k--) begin
            e.digit_char = rev[k];
            e.key_hash   = topic_hash;
            e.last_digit = (k == 0);
            key_digit_q.insert(key_digit_q.size(), e);
          end
          topic_hash = OFFSET_BASIS;
        end
      end
      if (pop && !empty) begin
        if (key_digit_q.size() == 0) begin
          $error("digit transfer with nothing expected: %h", out_item);
          errors++;
        end else begin
          e = key_digit_q.pop_front();
          if (out_item.digit_char !== e.digit_char) begin
            $error("digit_char expected %0d actual %0d", e.digit_char, out_item.digit_char);
            errors++;
          end
          if (out_item.key_hash !== e.key_hash) begin
            $error("key_hash expected %h actual %h", e.key_hash, out_item.key_hash);
            errors++;
          end
          if (out_item.last_digit !== e.last_digit) begin
            $error("last_digit expected %0d actual %0d", e.last_digit, out_item.last_digit);
            errors++;
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    bit [23:0]   fwd_prefix [bit [31:0]];
    logic [31:0] h;
    logic [31:0] pinv;
    logic [31:0] mid;
    logic [39:0] zero_str;
    bit          found;
    int          b1, b2, b3, b4, b5;
    int          k, len, real_items;

    // empty string, then an item that carries nothing
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'ha5, 1'b0, 1'b0);
    // byte extremes
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b1);
    add_item(8'h61, 1'b1, 1'b1);
    // bare end marker after bytes, its data ignored
    add_item(8'h55, 1'b1, 1'b0);
    add_item(8'haa, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b1);
    // idle item inside a string
    add_item(8'h12, 1'b1, 1'b0);
    add_item(8'h34, 1'b0, 1'b0);
    add_item(8'h56, 1'b1, 1'b1);

    // zero hash: meet in the middle, three-byte prefixes forward, two bytes back from zero
    pinv = HASH_PRIME;
    repeat (5) pinv = pinv * (32'd2 - HASH_PRIME * pinv);
    for (b1 = 0; b1 < 256; b1++) begin
      for (b2 = 0; b2 < 256; b2++) begin
        for (b3 = 0; b3 < 8; b3++) begin
          h = fnv_step(fnv_step(fnv_step(OFFSET_BASIS, 8'(b1)), 8'(b2)), 8'(b3));
          fwd_prefix[h] = {8'(b1), 8'(b2), 8'(b3)};
        end
      end
    end
    found = 1'b0;
    for (b5 = 0; b5 < 256 && !found; b5++) begin
      for (b4 = 0; b4 < 256 && !found; b4++) begin
        mid = (32'(b5) * pinv) ^ 32'(b4);
        if (fwd_prefix.exists(mid)) begin
          zero_str = {fwd_prefix[mid], 8'(b4), 8'(b5)};
          found    = 1'b1;
        end
      end
    end
    fwd_prefix.delete();
    if (found) begin
      for (k = 4; k >= 0; k--) begin
        add_item(zero_str[8*k +: 8], 1'b1, k == 0);
      end
    end

    // random strings, mostly short, with stray idle items mixed in
    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(6) : $urandom_range(20);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(99) < 6) begin
          add_item(8'($urandom), 1'b0, 1'b0);
        end
        add_item(8'($urandom), 1'b1, 1'b0);
        real_items++;
      end
      add_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
      real_items++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (accepted < total_items) @(posedge clk);
    while (key_digit_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fbk_pkg.sv
sv/fbk_front.sv
sv/fbk_queue.sv
sv/fbk_back.sv
sv/fnv1a_base36_key.sv
sim/testbench.sv
